// File: hdl/mh64_pkg.sv
package mh64_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned HALF_W  = WORD_W / 2;
    localparam int unsigned VBYTE_W = 4;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned SEED_W  = 32;

    localparam logic [WORD_W-1:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
    localparam int unsigned       MIX_SHIFT  = 47;
    localparam logic [SEED_W-1:0] SEED_RESET = 32'd5;

    // request to the shared multiplier
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] operand;
    } mul_req_t;

    // response from the shared multiplier
    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] product;
    } mul_rsp_t;

endpackage

// File: hdl/mh64_if.sv
interface mh64_msg_if;
    import mh64_pkg::*;

    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  data_word;
    logic [VBYTE_W-1:0] valid_bytes;
    logic [LEN_W-1:0]   message_length;
    logic               first_word;
    logic               last_word;

    modport source (output valid, data_word, valid_bytes, message_length, first_word,
                    last_word, input ready);
    modport sink (input valid, data_word, valid_bytes, message_length, first_word,
                  last_word, output ready);
endinterface

interface mh64_res_if;
    import mh64_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink (input valid, hash_value, output ready);
endinterface

interface mh64_cfg_if;
    import mh64_pkg::*;

    logic              valid;
    logic              ready;
    logic [SEED_W-1:0] hash_seed;

    modport source (output valid, hash_seed, input ready);
    modport sink (input valid, hash_seed, output ready);
endinterface

// File: hdl/mh64_mul.sv
module mh64_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  mh64_pkg::mul_req_t req,
    output mh64_pkg::mul_rsp_t rsp
);
    import mh64_pkg::*;

    typedef enum logic [1:0] {
        STEP_LL,
        STEP_HL,
        STEP_LH
    } step_t;

    step_t             step_reg;
    logic              active_reg;
    logic              done_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] acc_reg;

    logic [HALF_W-1:0] mul_x;
    logic [HALF_W-1:0] mul_y;
    logic [WORD_W-1:0] mul_p;

    // one 32x32 multiplier, three partial products, low 64 bits kept
    always_comb
    begin
        mul_x = a_reg[HALF_W-1:0];
        mul_y = MIX_MUL[HALF_W-1:0];
        case (step_reg)
            STEP_HL: mul_x = a_reg[WORD_W-1:HALF_W];
            STEP_LH: mul_y = MIX_MUL[WORD_W-1:HALF_W];
            default: ;
        endcase
    end

    assign mul_p = WORD_W'(mul_x) * WORD_W'(mul_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_LL;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            // done pulses for one cycle after the last partial product
            done_reg <= !req.start && active_reg && (step_reg == STEP_LH);
            if (req.start)
            begin
                step_reg   <= STEP_LL;
                active_reg <= 1'b1;
            end
            else if (active_reg)
            begin
                case (step_reg)
                    STEP_LL: step_reg <= STEP_HL;
                    STEP_HL: step_reg <= STEP_LH;
                    default:
                    begin
                        step_reg   <= STEP_LL;
                        active_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.operand;
        end
        else if (active_reg)
        begin
            if (step_reg == STEP_LL)
            begin
                acc_reg <= mul_p;
            end
            else
            begin
                acc_reg[WORD_W-1:HALF_W] <= acc_reg[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0];
            end
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// File: hdl/murmur64a_hash.sv
// murmur64a hash engine, one message word per request
// each multiply by the mixing constant runs on the shared 32x32 multiplier
// full word: three multiplies, tail word: one, zero-byte word: none, or one (finalizer) when last
// first word adds one multiply (length times constant), last word with bytes adds one (finalizer)
// not ready while a word is in flight; the result register frees the input side
// rst_n asynchronous active low: seed 5, running hash 0, no result pending
module murmur64a_hash (
    input logic       clk,
    input logic       rst_n,
    mh64_msg_if.sink  msg,
    mh64_res_if.source result,
    mh64_cfg_if.sink  cfg
);
    import mh64_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_MIX1,
        S_MIX2,
        S_HMUL,
        S_FIN,
        S_HOLD
    } state_t;

    state_t             state_reg, state_next;
    logic [WORD_W-1:0]  h_reg, h_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [VBYTE_W-1:0] vbytes_reg, vbytes_next;
    logic               last_reg, last_next;
    logic [SEED_W-1:0]  seed_reg, seed_next;
    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_hash_reg, out_hash_next;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    // fields seen by the dispatch step: live request in idle, latched after seeding
    logic [WORD_W-1:0]  d_word;
    logic [VBYTE_W-1:0] d_vbytes;
    logic               d_last;
    logic [WORD_W-1:0]  d_h;
    logic [WORD_W-1:0]  fin_val;
    logic               out_free;

    function automatic logic [WORD_W-1:0] shift_xor(input logic [WORD_W-1:0] x);
        shift_xor = x ^ (x >> MIX_SHIFT);
    endfunction

    // keeps the low vb bytes of the word
    function automatic logic [WORD_W-1:0] tail_bytes(input logic [WORD_W-1:0] w,
                                                     input logic [2:0]        vb);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (3'(i) < vb)
            begin
                m[i*8 +: 8] = 8'hff;
            end
        end
        tail_bytes = w & m;
    endfunction

    mh64_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign msg.ready        = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign result.valid     = out_valid_reg;
    assign result.hash_value = out_hash_reg;

    assign out_free = !out_valid_reg || result.ready;
    assign fin_val  = shift_xor(mul_rsp.product);

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            d_word   = msg.data_word;
            d_vbytes = msg.valid_bytes;
            d_last   = msg.last_word;
            d_h      = h_reg;
        end
        else
        begin
            d_word   = word_reg;
            d_vbytes = vbytes_reg;
            d_last   = last_reg;
            d_h      = WORD_W'(seed_reg) ^ mul_rsp.product;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        word_next      = word_reg;
        vbytes_next    = vbytes_reg;
        last_next      = last_reg;
        seed_next      = seed_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_hash_next  = out_hash_reg;
        mul_req        = '0;

        if (cfg.valid)
        begin
            seed_next = cfg.hash_seed;
        end

        case (state_reg)
            S_IDLE, S_SEED:
            begin
                if ((state_reg == S_IDLE && msg.valid && msg.first_word) )
                begin
                    // initial hash needs length times constant first
                    word_next       = msg.data_word;
                    vbytes_next     = msg.valid_bytes;
                    last_next       = msg.last_word;
                    mul_req.start   = 1'b1;
                    mul_req.operand = WORD_W'(msg.message_length);
                    state_next      = S_SEED;
                end
                else if ((state_reg == S_IDLE && msg.valid) ||
                         (state_reg == S_SEED && mul_rsp.done))
                begin
                    word_next   = d_word;
                    vbytes_next = d_vbytes;
                    last_next   = d_last;
                    h_next      = d_h;
                    if (d_vbytes[VBYTE_W-1])
                    begin
                        // eight or more bytes: full word mix
                        mul_req.start   = 1'b1;
                        mul_req.operand = d_word;
                        state_next      = S_MIX1;
                    end
                    else if (d_vbytes != '0)
                    begin
                        // tail bytes go straight into the hash
                        mul_req.start   = 1'b1;
                        mul_req.operand = d_h ^ tail_bytes(d_word, d_vbytes[2:0]);
                        state_next      = S_HMUL;
                    end
                    else if (d_last)
                    begin
                        mul_req.start   = 1'b1;
                        mul_req.operand = shift_xor(d_h);
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_MIX1:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = shift_xor(mul_rsp.product);
                    state_next      = S_MIX2;
                end
            end
            S_MIX2:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = h_reg ^ mul_rsp.product;
                    state_next      = S_HMUL;
                end
            end
            S_HMUL:
            begin
                if (mul_rsp.done)
                begin
                    h_next = mul_rsp.product;
                    if (last_reg)
                    begin
                        mul_req.start   = 1'b1;
                        mul_req.operand = shift_xor(mul_rsp.product);
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FIN:
            begin
                if (mul_rsp.done)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_hash_next  = fin_val;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        // result slot still full, park the hash
                        word_next  = fin_val;
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = word_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            h_reg         <= '0;
            word_reg      <= '0;
            vbytes_reg    <= '0;
            last_reg      <= 1'b0;
            seed_reg      <= SEED_RESET;
            out_valid_reg <= 1'b0;
            out_hash_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            word_reg      <= word_next;
            vbytes_reg    <= vbytes_next;
            last_reg      <= last_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
            out_hash_reg  <= out_hash_next;
        end
    end

endmodule

// File: hdl/mh64_checker.sv
module mh64_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        msg_valid,
    input logic        msg_ready,
    input logic [3:0]  msg_valid_bytes,
    input logic        msg_first_word,
    input logic        msg_last_word,
    input logic        res_valid,
    input logic        res_ready,
    input logic [63:0] res_hash
);

    // a pending result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_hash))
    else $error("result dropped or changed while stalled");

    // any word carrying bytes keeps the engine busy
    assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && (msg_valid_bytes != 4'd0) |=> !msg_ready)
    else $error("ready right after a word with bytes");

    // an empty middle word does not stall the input
    assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && (msg_valid_bytes == 4'd0) && !msg_first_word
        && !msg_last_word |=> msg_ready)
    else $error("empty middle word stalled the input");

    // a new result only comes out of finalization
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!msg_ready))
    else $error("result appeared while idle");

endmodule

bind murmur64a_hash mh64_checker u_mh64_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .msg_valid       (msg.valid),
    .msg_ready       (msg.ready),
    .msg_valid_bytes (msg.valid_bytes),
    .msg_first_word  (msg.first_word),
    .msg_last_word   (msg.last_word),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_hash        (result.hash_value)
);
